FILE: rtl/core/msts_pkg.sv
// ----------------------------------------------------------------------------
// Max-subarray segment tree package
// Shared types, codes and the summary merge used by the segment tree unit.
// ----------------------------------------------------------------------------
package msts_pkg;

   localparam int SUM_W             = 48;
   localparam int IDX_W             = 17;
   localparam int VAL_W             = 32;
   localparam int OP_W              = 2;
   localparam int ST_W              = 2;
   localparam int MAX_ELEMENTS_DEF  = 65536;
   localparam int VALUE_WIDTH_DEF   = 32;
   localparam logic [IDX_W-1:0] COUNT_RESET = 17'h10000;

   localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
   localparam logic [OP_W-1:0] OP_BUILD = 2'd1;
   localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

   localparam logic [ST_W-1:0] ST_OK        = 2'd0;
   localparam logic [ST_W-1:0] ST_BAD_RANGE = 2'd1;
   localparam logic [ST_W-1:0] ST_NOT_BUILT = 2'd2;

   typedef logic signed [SUM_W-1:0] sum_type;

   localparam sum_type SAT_HI = 48'sh7FFF_FFFF_FFFF;
   localparam sum_type SAT_LO = 48'sh8000_0000_0000;

   typedef struct packed {
      sum_type total;
      sum_type best;
      sum_type prefix;
      sum_type suffix;
   } summ_type;

   typedef struct packed {
      logic [OP_W-1:0]  opcode;
      logic [IDX_W-1:0] elem_index;
      logic [VAL_W-1:0] elem_value;
      logic [IDX_W-1:0] range_left;
      logic [IDX_W-1:0] range_right;
   } req_type;

   typedef struct packed {
      logic            vld;
      logic [ST_W-1:0] status;
      summ_type        sum;
   } result_type;

   function automatic sum_type sat_add(sum_type a, sum_type b);
      logic signed [SUM_W:0] s;
      s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
      if (s[SUM_W] != s[SUM_W-1]) begin
         return s[SUM_W] ? SAT_LO : SAT_HI;
      end
      return s[SUM_W-1:0];
   endfunction

   function automatic sum_type max2(sum_type a, sum_type b);
      return (a > b) ? a : b;
   endfunction

   // Summary of span a followed directly by span b.
   function automatic summ_type join_span(summ_type a, summ_type b);
      summ_type r;
      r.total  = sat_add(a.total, b.total);
      r.prefix = max2(a.prefix, sat_add(a.total, b.prefix));
      r.suffix = max2(b.suffix, sat_add(b.total, a.suffix));
      r.best   = max2(sat_add(a.suffix, b.prefix), max2(a.best, b.best));
      return r;
   endfunction

endpackage

FILE: rtl/core/msts_node_mem.sv
// ----------------------------------------------------------------------------
// Node summary memory
// Single-port-write, single-port-read store of span summaries, heap ordered,
// with leaves in the upper half. Read data is registered.
// ----------------------------------------------------------------------------
module msts_node_mem #(
   parameter int ADDR_W = 17
) (
   input  logic                clock,
   input  logic                rd_en,
   input  logic [ADDR_W-1:0]   rd_addr,
   output msts_pkg::summ_type  rd_data,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  msts_pkg::summ_type  wr_data
);
   import msts_pkg::*;

   localparam int DEPTH = 2 ** ADDR_W;

   summ_type mem_q [0:DEPTH-1];
   summ_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_q[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_q[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/msts_seq.sv
// ----------------------------------------------------------------------------
// Segment tree sequencer
// Runs loads, the bottom-up build and the query walk against the node memory.
// ----------------------------------------------------------------------------
module msts_seq #(
   parameter int MAX_ELEMENTS = msts_pkg::MAX_ELEMENTS_DEF,
   parameter int VALUE_WIDTH  = msts_pkg::VALUE_WIDTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  msts_pkg::req_type                    req,
   input  logic                                 csr_wr,
   input  logic [$clog2(MAX_ELEMENTS+1)-1:0]    use_count,
   output logic                                 rd_en,
   output logic [$clog2(MAX_ELEMENTS):0]        rd_addr,
   input  msts_pkg::summ_type                   rd_data,
   output logic                                 wr_en,
   output logic [$clog2(MAX_ELEMENTS):0]        wr_addr,
   output msts_pkg::summ_type                   wr_data,
   output msts_pkg::result_type                 result
);
   import msts_pkg::*;

   localparam int LOG    = $clog2(MAX_ELEMENTS);
   localparam int ADDR_W = LOG + 1;
   localparam int HEAP_W = LOG + 2;
   localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);
   localparam logic [HEAP_W-1:0] LEAF_BASE = HEAP_W'(2 ** LOG);
   localparam logic [ADDR_W-1:0] LAST_NODE = ADDR_W'(2 ** LOG - 1);

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_BUILD_A = 3'd1;
   localparam logic [2:0] S_BUILD_B = 3'd2;
   localparam logic [2:0] S_BUILD_C = 3'd3;
   localparam logic [2:0] S_QUERY   = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic [ADDR_W-1:0] node_ff, node_in;
   logic [HEAP_W-1:0] hl_ff, hl_in, hr_ff, hr_in;
   summ_type          lacc_ff, lacc_in, racc_ff, racc_in;
   logic              lvld_ff, lvld_in, rvld_ff, rvld_in;
   logic              pend_ff, pend_in, side_ff, side_in;
   logic              built_ff, built_in;
   logic [CNT_W-1:0]  bcnt_ff, bcnt_in;
   result_type        res_ff, res_in;

   logic              accept;
   logic              idx_ok;
   logic              range_bad;
   logic [VALUE_WIDTH-1:0] val_raw;
   sum_type           leaf_v;

   assign accept  = start && (state_ff == S_IDLE);
   assign busy    = (state_ff != S_IDLE);
   assign result  = res_ff;
   assign val_raw = req.elem_value[VALUE_WIDTH-1:0];
   assign leaf_v  = {{(SUM_W-VALUE_WIDTH){val_raw[VALUE_WIDTH-1]}}, val_raw};
   assign idx_ok  = (req.elem_index != '0) && (32'(req.elem_index) <= MAX_ELEMENTS);
   assign range_bad = (req.range_left == '0) || (req.range_left > req.range_right)
                   || (32'(req.range_right) > 32'(bcnt_ff));

   always_comb begin
      state_in = state_ff;
      node_in  = node_ff;
      hl_in    = hl_ff;
      hr_in    = hr_ff;
      lacc_in  = lacc_ff;
      racc_in  = racc_ff;
      lvld_in  = lvld_ff;
      rvld_in  = rvld_ff;
      pend_in  = pend_ff;
      side_in  = side_ff;
      built_in = built_ff;
      bcnt_in  = bcnt_ff;
      res_in   = '0;
      rd_en    = 1'b0;
      rd_addr  = '0;
      wr_en    = 1'b0;
      wr_addr  = '0;
      wr_data  = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               res_in.vld = 1'b1;
               case (req.opcode)
                  OP_LOAD: begin
                     if (idx_ok) begin
                        wr_en          = 1'b1;
                        wr_addr        = ADDR_W'(LEAF_BASE + HEAP_W'(req.elem_index)
                                                 - HEAP_W'(1));
                        wr_data.total  = leaf_v;
                        wr_data.best   = leaf_v;
                        wr_data.prefix = leaf_v;
                        wr_data.suffix = leaf_v;
                        built_in       = 1'b0;
                     end else begin
                        res_in.status = ST_BAD_RANGE;
                     end
                  end
                  OP_BUILD: begin
                     res_in.vld = 1'b0;
                     bcnt_in    = use_count;
                     node_in    = LAST_NODE;
                     state_in   = S_BUILD_A;
                  end
                  OP_QUERY: begin
                     if (!built_ff) begin
                        res_in.status = ST_NOT_BUILT;
                     end else if (range_bad) begin
                        res_in.status = ST_BAD_RANGE;
                     end else begin
                        res_in.vld = 1'b0;
                        hl_in      = LEAF_BASE + HEAP_W'(req.range_left) - HEAP_W'(1);
                        hr_in      = LEAF_BASE + HEAP_W'(req.range_right);
                        lvld_in    = 1'b0;
                        rvld_in    = 1'b0;
                        pend_in    = 1'b0;
                        state_in   = S_QUERY;
                     end
                  end
                  default: begin
                     res_in.status = ST_OK;
                  end
               endcase
            end
            if (csr_wr) begin
               built_in = 1'b0;
            end
         end
         S_BUILD_A: begin
            rd_en    = 1'b1;
            rd_addr  = {node_ff[LOG-1:0], 1'b0};
            state_in = S_BUILD_B;
         end
         S_BUILD_B: begin
            rd_en    = 1'b1;
            rd_addr  = {node_ff[LOG-1:0], 1'b1};
            lacc_in  = rd_data;
            state_in = S_BUILD_C;
         end
         S_BUILD_C: begin
            wr_en   = 1'b1;
            wr_addr = node_ff;
            wr_data = join_span(lacc_ff, rd_data);
            if (node_ff == ADDR_W'(1)) begin
               built_in   = 1'b1;
               res_in.vld = 1'b1;
               state_in   = S_IDLE;
            end else begin
               node_in  = node_ff - ADDR_W'(1);
               state_in = S_BUILD_A;
            end
         end
         S_QUERY: begin
            // Fold in the node read last cycle: left edge grows rightwards,
            // right edge grows leftwards.
            if (pend_ff) begin
               if (side_ff) begin
                  racc_in = rvld_ff ? join_span(rd_data, racc_ff) : rd_data;
                  rvld_in = 1'b1;
               end else begin
                  lacc_in = lvld_ff ? join_span(lacc_ff, rd_data) : rd_data;
                  lvld_in = 1'b1;
               end
            end
            pend_in = 1'b0;
            if (hl_ff < hr_ff) begin
               if (hl_ff[0]) begin
                  rd_en   = 1'b1;
                  rd_addr = ADDR_W'(hl_ff);
                  pend_in = 1'b1;
                  side_in = 1'b0;
                  if (hr_ff[0]) begin
                     hl_in = hl_ff + HEAP_W'(1);
                  end else begin
                     hl_in = (hl_ff + HEAP_W'(1)) >> 1;
                     hr_in = hr_ff >> 1;
                  end
               end else if (hr_ff[0]) begin
                  rd_en   = 1'b1;
                  rd_addr = ADDR_W'(hr_ff - HEAP_W'(1));
                  pend_in = 1'b1;
                  side_in = 1'b1;
                  hl_in   = hl_ff >> 1;
                  hr_in   = (hr_ff - HEAP_W'(1)) >> 1;
               end else begin
                  hl_in = hl_ff >> 1;
                  hr_in = hr_ff >> 1;
               end
            end else if (!pend_ff) begin
               res_in.vld    = 1'b1;
               res_in.status = ST_OK;
               if (lvld_ff && rvld_ff) begin
                  res_in.sum = join_span(lacc_ff, racc_ff);
               end else if (lvld_ff) begin
                  res_in.sum = lacc_ff;
               end else begin
                  res_in.sum = racc_ff;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         built_ff <= 1'b0;
         pend_ff  <= 1'b0;
         res_ff   <= '0;
      end else begin
         state_ff <= state_in;
         built_ff <= built_in;
         pend_ff  <= pend_in;
         res_ff   <= res_in;
      end
   end

   always_ff @(posedge clock) begin
      node_ff <= node_in;
      hl_ff   <= hl_in;
      hr_ff   <= hr_in;
      lacc_ff <= lacc_in;
      racc_ff <= racc_in;
      lvld_ff <= lvld_in;
      rvld_ff <= rvld_in;
      side_ff <= side_in;
      bcnt_ff <= bcnt_in;
   end

   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      (wr_en && rd_en) |-> (wr_addr != rd_addr))
      else $error("node memory read and written at the same entry");

   a_query_needs_tree: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_QUERY) |-> built_ff)
      else $error("query walk running without a built tree");

   a_build_done_reports: assert property (@(posedge clock) disable iff (reset)
      $rose(built_ff) |-> (res_ff.vld && res_ff.status == ST_OK))
      else $error("build finished without a result beat");

   a_build_node_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_BUILD_C) |-> (node_ff != '0))
      else $error("build reached node zero");

endmodule

FILE: rtl/core/multiway_segment_tree_max_subarray_unit.sv
// ----------------------------------------------------------------------------
// Max-subarray segment tree unit
// Answers maximum-subarray-sum range queries over loaded signed elements.
// ----------------------------------------------------------------------------
// A load, an unused opcode, a query before a build or a query with a bad range
// gives its result beat in the cycle after start is taken. A build sweeps every
// internal node of the tree from the bottom up, as both children pass through
// the single read port of the node memory before the node is written. A query
// reads at most two nodes per tree level, one per cycle, then folds the last
// read and forms the result. The result beat comes in the cycle in which busy
// falls again; rsp_valid lasts one cycle and cannot be held off by the
// receiver. The element count register is always ready.
module multiway_segment_tree_max_subarray_unit #(
   parameter int MAX_ELEMENTS = msts_pkg::MAX_ELEMENTS_DEF,
   parameter int VALUE_WIDTH  = msts_pkg::VALUE_WIDTH_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic [msts_pkg::OP_W-1:0]              req_opcode,
   input  logic [msts_pkg::IDX_W-1:0]             req_elem_index,
   input  logic signed [msts_pkg::VAL_W-1:0]      req_elem_value,
   input  logic [msts_pkg::IDX_W-1:0]             req_range_left,
   input  logic [msts_pkg::IDX_W-1:0]             req_range_right,
   output logic                                   rsp_valid,
   output logic [msts_pkg::ST_W-1:0]              rsp_status,
   output logic signed [msts_pkg::SUM_W-1:0]      rsp_best_sum,
   output logic signed [msts_pkg::SUM_W-1:0]      rsp_range_sum,
   output logic signed [msts_pkg::SUM_W-1:0]      rsp_best_prefix,
   output logic signed [msts_pkg::SUM_W-1:0]      rsp_best_suffix,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [msts_pkg::IDX_W-1:0]             csr_element_count
);
   import msts_pkg::*;

   localparam int ADDR_W = $clog2(MAX_ELEMENTS) + 1;
   localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);

   logic [IDX_W-1:0]  element_count_ff, element_count_in;
   logic [CNT_W-1:0]  use_count;
   logic              csr_wr;
   req_type           req;
   result_type        result;
   logic              rd_en, wr_en;
   logic [ADDR_W-1:0] rd_addr, wr_addr;
   summ_type          rd_data, wr_data;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;
   assign element_count_in = csr_wr ? csr_element_count : element_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         element_count_ff <= COUNT_RESET;
      end else begin
         element_count_ff <= element_count_in;
      end
   end

   // A count of zero acts as one element, anything past the store as full.
   always_comb begin
      if (element_count_ff == '0) begin
         use_count = CNT_W'(1);
      end else if (32'(element_count_ff) > MAX_ELEMENTS) begin
         use_count = CNT_W'(MAX_ELEMENTS);
      end else begin
         use_count = CNT_W'(element_count_ff);
      end
   end

   assign req.opcode      = req_opcode;
   assign req.elem_index  = req_elem_index;
   assign req.elem_value  = req_elem_value;
   assign req.range_left  = req_range_left;
   assign req.range_right = req_range_right;

   msts_seq #(
      .MAX_ELEMENTS (MAX_ELEMENTS),
      .VALUE_WIDTH  (VALUE_WIDTH)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req       (req),
      .csr_wr    (csr_wr),
      .use_count (use_count),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .result    (result)
   );

   msts_node_mem #(
      .ADDR_W (ADDR_W)
   ) u_mem (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   assign rsp_valid       = result.vld;
   assign rsp_status      = result.status;
   assign rsp_best_sum    = result.sum.best;
   assign rsp_range_sum   = result.sum.total;
   assign rsp_best_prefix = result.sum.prefix;
   assign rsp_best_suffix = result.sum.suffix;

endmodule

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// Segment tree max-subarray unit testbench
// Loads elements, builds the tree under several element counts and checks
// every result beat of loads, builds, unused opcodes and range queries against
// a five-way behavioural tree kept in a scoreboard class.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import msts_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int MAX_EL     = 65536;
   localparam int NODE_CAP   = MAX_EL;
   localparam int SPAN_SLOTS = 10;
   localparam int FAN        = 5;
   localparam longint LIMIT  = 6000000;
   localparam longint SUM_HI = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint SUM_LO = -SUM_HI - 1;

   typedef struct {
      longint t;
      longint b;
      longint p;
      longint s;
   } span_type;

   typedef struct {
      logic [ST_W-1:0] status;
      span_type        figs;
   } answer_type;

   class tree_scoreboard_type;
      int            store [MAX_EL+1];
      longint        ntot [NODE_CAP];
      longint        nbest [NODE_CAP];
      longint        npre [NODE_CAP];
      longint        nsuf [NODE_CAP];
      span_type      runs [NODE_CAP][SPAN_SLOTS];
      int unsigned   links [NODE_CAP][FAN];
      int unsigned   count_reg;
      int unsigned   built_count;
      int unsigned   nodes_used;
      bit            built;
      answer_type    awaited[$];
      int            errors;
      int            checked;

      function void clear();
         count_reg = MAX_EL;
         built = 0;
         nodes_used = 0;
         built_count = 1;
      endfunction

      task report(string what);
         errors++;
         $display("[%0t] mismatch: %s", $realtime, what);
      endtask

      function longint sat(longint v);
         if (v > SUM_HI) return SUM_HI;
         if (v < SUM_LO) return SUM_LO;
         return v;
      endfunction

      function longint mx(longint a, longint b);
         return a > b ? a : b;
      endfunction

      function span_type join2(span_type a, span_type b);
         span_type r;
         r.t = sat(a.t + b.t);
         r.p = mx(a.p, sat(a.t + b.p));
         r.s = mx(b.s, sat(b.t + a.s));
         r.b = mx(sat(a.s + b.p), mx(a.b, b.b));
         return r;
      endfunction

      function span_type leaf(int unsigned i);
         span_type r;
         longint v;
         v = (i <= MAX_EL) ? longint'(store[i]) : 0;
         r.t = v; r.b = v; r.p = v; r.s = v;
         return r;
      endfunction

      function span_type node_get(int unsigned id);
         span_type r;
         r = '{0, 0, 0, 0};
         if (id < NODE_CAP) r = '{ntot[id], nbest[id], npre[id], nsuf[id]};
         return r;
      endfunction

      function int unsigned kids_of(int unsigned l, int unsigned r, int unsigned w);
         int unsigned c;
         c = 0;
         while (c < FAN && l + c * w <= r) c++;
         return c;
      endfunction

      function int unsigned slot(int unsigned i, int unsigned j);
         int unsigned k;
         k = (i - 1) * (FAN - 2) + (j - 1);
         return k < SPAN_SLOTS ? k : SPAN_SLOTS - 1;
      endfunction

      function int unsigned grow(int unsigned l, int unsigned r);
         span_type kids [FAN];
         span_type acc;
         int unsigned seg, w, nc, id, cl, cr;
         seg = (r - l) / FAN;
         w = seg + 1;
         nc = kids_of(l, r, w);
         id = nodes_used;
         if (id >= NODE_CAP) return NODE_CAP - 1;
         nodes_used++;
         for (int unsigned c = 0; c < nc; c++) begin
            cl = l + c * w;
            cr = cl + seg;
            if (cr > r) cr = r;
            if (cl == cr) begin
               kids[c] = leaf(cl);
               links[id][c] = 0;
            end else begin
               links[id][c] = grow(cl, cr);
               kids[c] = node_get(links[id][c]);
            end
         end
         acc = kids[0];
         for (int unsigned c = 1; c < nc; c++) acc = join2(acc, kids[c]);
         ntot[id] = acc.t; nbest[id] = acc.b; npre[id] = acc.p; nsuf[id] = acc.s;
         for (int unsigned i = 1; i + 1 < nc; i++) begin
            acc = kids[i];
            for (int unsigned j = i; j + 1 < nc; j++) begin
               if (j > i) acc = join2(acc, kids[j]);
               runs[id][slot(i, j)] = acc;
            end
         end
         return id;
      endfunction

      function span_type walk_child(int unsigned id, int unsigned c, int unsigned cl,
                                    int unsigned cr, int unsigned a, int unsigned b);
         if (cl == cr) return leaf(cl);
         return walk(links[id][c], cl, cr, a, b);
      endfunction

      function span_type walk(int unsigned id, int unsigned l, int unsigned r,
                              int unsigned a, int unsigned b);
         int unsigned seg, w, nc, cl, cr, sl, el, sr, er;
         span_type lhs, rhs;
         if (a <= l && b >= r) return node_get(id);
         if (id >= NODE_CAP) return node_get(id);
         seg = (r - l) / FAN;
         w = seg + 1;
         nc = kids_of(l, r, w);
         cl = (a - l) / w;
         cr = (b - l) / w;
         if (cl >= nc) cl = nc - 1;
         if (cr >= nc) cr = nc - 1;
         sl = l + cl * w; el = sl + seg; if (el > r) el = r;
         sr = l + cr * w; er = sr + seg; if (er > r) er = r;
         if (cl >= cr) return walk_child(id, cl, sl, el, a, b);
         lhs = walk_child(id, cl, sl, el, a, el);
         rhs = walk_child(id, cr, sr, er, sr, b);
         if (cr > cl + 1) lhs = join2(lhs, runs[id][slot(cl + 1, cr - 1)]);
         return join2(lhs, rhs);
      endfunction

      function void set_count(logic [IDX_W-1:0] v);
         count_reg = v;
         built = 0;
      endfunction

      // Works out the beat that an accepted request must produce.
      function void note(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
                         logic [VAL_W-1:0] val, logic [IDX_W-1:0] a,
                         logic [IDX_W-1:0] b);
         answer_type ans;
         ans.status = ST_OK;
         ans.figs = '{0, 0, 0, 0};
         if (op == OP_LOAD) begin
            if (idx == 0 || idx > MAX_EL) ans.status = ST_BAD_RANGE;
            else begin
               store[idx] = signed'(val);
               built = 0;
            end
         end else if (op == OP_BUILD) begin
            built_count = (count_reg == 0) ? 1 : (count_reg > MAX_EL ? MAX_EL : count_reg);
            nodes_used = 0;
            if (built_count > 1) void'(grow(1, built_count));
            built = 1;
         end else if (op == OP_QUERY) begin
            if (!built) ans.status = ST_NOT_BUILT;
            else if (a == 0 || a > b || b > built_count) ans.status = ST_BAD_RANGE;
            else if (built_count == 1) ans.figs = leaf(1);
            else ans.figs = walk(0, 1, built_count, a, b);
         end
         awaited = {awaited, ans};
      endfunction

      task check(logic [ST_W-1:0] st, logic [SUM_W-1:0] bs, logic [SUM_W-1:0] rs,
                 logic [SUM_W-1:0] bp, logic [SUM_W-1:0] bx);
         answer_type e;
         logic [SUM_W-1:0] eb, et, ep, es;
         if (awaited.size() == 0) begin
            report($sformatf("result beat with nothing outstanding, status %0d", st));
            return;
         end
         e = awaited.pop_front();
         checked++;
         eb = e.figs.b[SUM_W-1:0];
         et = e.figs.t[SUM_W-1:0];
         ep = e.figs.p[SUM_W-1:0];
         es = e.figs.s[SUM_W-1:0];
         if (st !== e.status) report($sformatf("status %0d, wanted %0d", st, e.status));
         if (bs !== eb) report($sformatf("best_sum %0h, wanted %0h", bs, eb));
         if (rs !== et) report($sformatf("range_sum %0h, wanted %0h", rs, et));
         if (bp !== ep) report($sformatf("best_prefix %0h, wanted %0h", bp, ep));
         if (bx !== es) report($sformatf("best_suffix %0h, wanted %0h", bx, es));
      endtask
   endclass

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic [OP_W-1:0]  req_opcode = '0;
   logic [IDX_W-1:0] req_elem_index = '0;
   logic signed [VAL_W-1:0] req_elem_value = '0;
   logic [IDX_W-1:0] req_range_left = '0;
   logic [IDX_W-1:0] req_range_right = '0;
   logic rsp_valid;
   logic [ST_W-1:0] rsp_status;
   logic signed [SUM_W-1:0] rsp_best_sum, rsp_range_sum, rsp_best_prefix, rsp_best_suffix;
   logic csr_valid = 0;
   logic csr_ready;
   logic [IDX_W-1:0] csr_element_count = '0;

   tree_scoreboard_type sb = new();
   longint cycles = 0;
   int queries = 0;
   int builds = 0;

   always #1 clock = ~clock;

   multiway_segment_tree_max_subarray_unit dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_opcode(req_opcode), .req_elem_index(req_elem_index),
      .req_elem_value(req_elem_value), .req_range_left(req_range_left),
      .req_range_right(req_range_right), .rsp_valid(rsp_valid),
      .rsp_status(rsp_status), .rsp_best_sum(rsp_best_sum),
      .rsp_range_sum(rsp_range_sum), .rsp_best_prefix(rsp_best_prefix),
      .rsp_best_suffix(rsp_best_suffix), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_element_count(csr_element_count)
   );

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check(rsp_status, rsp_best_sum, rsp_range_sum, rsp_best_prefix,
                  rsp_best_suffix);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Mostly back to back, sometimes a short pause, now and then a long one unless quick.
   task idle_gap(input bit quick);
      int unsigned k, n;
      k = $urandom_range(0, 99);
      n = 0;
      if (quick) n = (k < 80) ? 0 : 1;
      else if (k >= 95) n = $urandom_range(20, 60);
      else if (k >= 55) n = $urandom_range(1, 3);
      repeat (n) @(negedge clock);
   endtask

   // Called at a falling edge; returns at a falling edge after the beat is taken.
   task send(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
             input logic [VAL_W-1:0] val, input logic [IDX_W-1:0] a,
             input logic [IDX_W-1:0] b, input bit quick = 0);
      req_opcode = op;
      req_elem_index = idx;
      req_elem_value = val;
      req_range_left = a;
      req_range_right = b;
      start = 1;
      do @(posedge clock); while (busy);
      sb.note(op, idx, val, a, b);
      if (op == OP_QUERY) queries++;
      if (op == OP_BUILD) builds++;
      @(negedge clock);
      start = 0;
      idle_gap(quick);
   endtask

   function logic [VAL_W-1:0] pick_value();
      int unsigned k;
      k = $urandom_range(0, 7);
      if (k == 0) return 32'h7FFF_FFFF;
      if (k == 1) return 32'h8000_0000;
      if (k == 2) return VAL_W'($signed($urandom_range(0, 16)) - 8);
      return $urandom;
   endfunction

   task drain();
      while (sb.awaited.size() != 0) @(negedge clock);
   endtask

   task write_count(input logic [IDX_W-1:0] v);
      drain();
      repeat (4) @(negedge clock);
      csr_element_count = v;
      csr_valid = 1;
      do @(posedge clock); while (!csr_ready);
      sb.set_count(v);
      @(negedge clock);
      csr_valid = 0;
   endtask

   task load(input logic [IDX_W-1:0] idx, input bit quick = 0);
      send(OP_LOAD, idx, pick_value(), IDX_W'($urandom), IDX_W'($urandom), quick);
   endtask

   task build();
      send(OP_BUILD, IDX_W'($urandom), VAL_W'($urandom), IDX_W'($urandom),
           IDX_W'($urandom));
   endtask

   // Mostly well-formed ranges, short or wide, with some malformed ones and the odd unused opcode.
   task random_query(input int unsigned n);
      int unsigned k, a, b;
      k = $urandom_range(0, 99);
      a = $urandom_range(1, n);
      b = $urandom_range(a, n);
      if (k < 35 && a + 12 <= n) b = $urandom_range(a, a + 12);
      else if (k < 45) begin
         a = 1; b = n;
      end else if (k < 50) a = 0;
      else if (k < 55 && n > 1) begin
         a = $urandom_range(2, n); b = $urandom_range(1, a - 1);
      end else if (k < 60) b = $urandom_range(n + 1, 131071);
      else if (k < 63) begin
         send(OP_UNUSED, IDX_W'($urandom), VAL_W'($urandom), IDX_W'($urandom),
              IDX_W'($urandom));
         return;
      end
      send(OP_QUERY, IDX_W'($urandom), VAL_W'($urandom), IDX_W'(a), IDX_W'(b));
   endtask

   initial begin
      int unsigned n;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 0;
      sb.clear();

      // Corner cases with no tree and a one-element tree.
      send(OP_QUERY, 0, 0, 1, 1);
      send(OP_UNUSED, 17'h1FFFF, 32'hFFFF_FFFF, 17'h1FFFF, 17'h1FFFF);
      send(OP_LOAD, 0, 32'h1234_5678, 0, 0);
      send(OP_LOAD, 17'h1FFFF, 32'h7FFF_FFFF, 0, 0);
      send(OP_LOAD, 17'h10001, 32'h7FFF_FFFF, 0, 0);
      send(OP_LOAD, 17'h10000, 32'h7FFF_FFFF, 0, 0);
      send(OP_LOAD, 1, 32'h8000_0000, 0, 0);
      send(OP_QUERY, 0, 0, 1, 1);
      write_count(0);
      build();
      send(OP_QUERY, 0, 0, 1, 1);
      send(OP_QUERY, 0, 0, 0, 1);
      send(OP_QUERY, 0, 0, 1, 2);
      send(OP_QUERY, 0, 0, 2, 1);
      send(OP_QUERY, 0, 0, 17'h1FFFF, 17'h1FFFF);

      // Writes of the count leave the tree stale.
      write_count(17'h1FFFF);
      send(OP_QUERY, 0, 0, 1, 1);
      write_count(17'h10000);
      send(OP_QUERY, 0, 0, 1, 2);

      write_count(26);
      for (int unsigned i = 1; i <= 26; i++) load(IDX_W'(i));
      build();
      for (int i = 0; i < 180; i++) random_query(26);

      n = $urandom_range(150, 300);
      write_count(IDX_W'(n));
      for (int unsigned i = 1; i <= n; i++) load(IDX_W'(i), 1);
      for (int i = 0; i < 40; i++) load(IDX_W'($urandom_range(1, n)), 1);
      build();
      send(OP_QUERY, 0, 0, 1, IDX_W'(n));
      send(OP_QUERY, 0, 0, IDX_W'(n), IDX_W'(n));
      send(OP_QUERY, 0, 0, 1, 1);
      for (int i = 0; i < 300; i++) begin
         random_query(n);
         if (i == 150) drain();
      end
      for (int i = 0; i < 40; i++) begin
         if ($urandom_range(0, 3) == 0) load(IDX_W'($urandom_range(1, MAX_EL)));
         else random_query(n);
      end

      drain();
      repeat (60) @(posedge clock);
      $display("covered %0d builds and %0d queries, %0d result beats compared",
               builds, queries, sb.checked);
      $display("trees built over 1, 26 and %0d elements; stale tree seen after count writes",
               n);
      if (sb.errors == 0 && sb.awaited.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
